// ===== rtl/core/rsbd_pkg.sv =====
// Shared types and constants for the record sort-by-date unit.
package rsbd_pkg;

  localparam int MAX_RECORDS_DEF = 32;

  localparam int ID_W    = 16;
  localparam int YEAR_W  = 14;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int PRICE_W = 32;
  localparam int KEY_W   = YEAR_W + MONTH_W + DAY_W;

  // The key packs year, month and day so that a plain unsigned compare orders dates.
  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [ID_W-1:0]    id;
    logic [PRICE_W-1:0] price;
  } rec_t;

  typedef struct packed {
    logic insert;
    logic shift;
  } cell_ctrl_t;

  typedef enum logic {
    ST_LOAD,
    ST_EMIT
  } state_t;

endpackage

// ===== rtl/core/rsbd_cell.sv =====
// One storage cell of the sorting row: holds a record and shifts it on insert or emit.
module rsbd_cell
  import rsbd_pkg::*;
(
  input  logic       clk,
  input  cell_ctrl_t ctrl,
  input  logic       cell_valid,
  input  rec_t       new_rec,
  input  rec_t       prev_rec,
  input  logic       prev_stay,
  input  rec_t       next_rec,
  output rec_t       rec,
  output logic       stay
);

  rec_t rec_r;
  rec_t rec_nxt;

  // A held record stays put when its date is not later than the new one,
  // which keeps equal dates in arrival order.
  assign stay = cell_valid && (rec_r.key <= new_rec.key);
  assign rec  = rec_r;

  always_comb begin
    rec_nxt = rec_r;
    if (ctrl.shift) begin
      rec_nxt = next_rec;
    end else if (ctrl.insert && !stay) begin
      rec_nxt = prev_stay ? new_rec : prev_rec;
    end
  end

  always_ff @(posedge clk) begin
    rec_r <= rec_nxt;
  end

endmodule

// ===== rtl/core/record_sort_by_date_key_unit.sv =====
// Top level of the record sorter: a row of cells sorts records by date as they arrive.
//
// Records are taken one per cycle while a set loads: each new record is placed in the
// row of MAX_RECORDS cells in the same cycle, all cells comparing their date with the
// new one at once. The item marked last ends the set; after it the block emits the held
// records in ascending date order, one per cycle as the output side takes them, by
// shifting the row toward cell zero; emission ends when the last held record moves
// into the output register, and in_stall is high throughout. Records beyond
// MAX_RECORDS are dropped and every result of that set carries out_overflowed. The
// next set may load while the final result still waits in the output register.
module record_sort_by_date_key_unit
  import rsbd_pkg::*;
#(
  parameter int MAX_RECORDS = MAX_RECORDS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [ID_W-1:0]    in_record_id,
  input  logic [YEAR_W-1:0]  in_expiry_year,
  input  logic [MONTH_W-1:0] in_expiry_month,
  input  logic [DAY_W-1:0]   in_expiry_day,
  input  logic [PRICE_W-1:0] in_price_bits,
  input  logic               in_last_item,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [ID_W-1:0]    out_id,
  output logic [YEAR_W-1:0]  out_year,
  output logic [MONTH_W-1:0] out_month,
  output logic [DAY_W-1:0]   out_day,
  output logic [PRICE_W-1:0] out_price_bits,
  output logic               out_final_result,
  output logic               out_overflowed
);

  localparam int CW = $clog2(MAX_RECORDS + 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(MAX_RECORDS);

  state_t         state_r, state_nxt;
  logic [CW-1:0]  count_r, count_nxt;
  logic           ovf_r, ovf_nxt;
  logic           out_valid_r, out_valid_nxt;
  rec_t           out_rec_r;
  logic           out_final_r, out_ovf_r;

  logic           in_accept;
  logic           out_load;
  logic           store_full;
  cell_ctrl_t     ctrl;
  rec_t           new_rec;
  rec_t           cell_rec  [MAX_RECORDS];
  logic           cell_stay [MAX_RECORDS];

  assign new_rec.key   = {in_expiry_year, in_expiry_month, in_expiry_day};
  assign new_rec.id    = in_record_id;
  assign new_rec.price = in_price_bits;

  assign store_full = (count_r == FULL_COUNT);
  assign in_accept  = in_valid && !in_stall;
  assign out_load   = (state_r == ST_EMIT) && (!out_valid_r || !out_stall);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_LOAD: begin
        if (in_accept && in_last_item) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_load && (count_r == CW'(1))) begin
          state_nxt = ST_LOAD;
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  // Outputs of the state machine.
  always_comb begin
    in_stall    = 1'b0;
    ctrl.insert = 1'b0;
    ctrl.shift  = 1'b0;
    case (state_r)
      ST_LOAD: begin
        ctrl.insert = in_accept && !store_full;
      end
      ST_EMIT: begin
        in_stall   = 1'b1;
        ctrl.shift = out_load;
      end
      default: in_stall = 1'b1;
    endcase
  end

  always_comb begin
    count_nxt     = count_r;
    ovf_nxt       = ovf_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (ctrl.insert) begin
      count_nxt = count_r + CW'(1);
    end else if (in_accept && store_full) begin
      ovf_nxt = 1'b1;
    end
    if (out_load) begin
      out_valid_nxt = 1'b1;
      count_nxt     = count_r - CW'(1);
      if (count_r == CW'(1)) begin
        ovf_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_rec_r   <= cell_rec[0];
      out_final_r <= (count_r == CW'(1));
      out_ovf_r   <= ovf_r;
    end
  end

  for (genvar i = 0; i < MAX_RECORDS; i++) begin : g_cell
    logic cell_valid;
    rec_t prev_rec, next_rec;
    logic prev_stay;

    assign cell_valid = (CW'(i) < count_r);

    if (i == 0) begin : g_head
      assign prev_rec  = new_rec;
      assign prev_stay = 1'b1;
    end else begin : g_body
      assign prev_rec  = cell_rec[i-1];
      assign prev_stay = cell_stay[i-1];
    end

    if (i == MAX_RECORDS - 1) begin : g_tail
      assign next_rec = cell_rec[i];
    end else begin : g_inner
      assign next_rec = cell_rec[i+1];
    end

    rsbd_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .cell_valid (cell_valid),
      .new_rec    (new_rec),
      .prev_rec   (prev_rec),
      .prev_stay  (prev_stay),
      .next_rec   (next_rec),
      .rec        (cell_rec[i]),
      .stay       (cell_stay[i])
    );
  end

  assign out_valid        = out_valid_r;
  assign out_id           = out_rec_r.id;
  assign out_year         = out_rec_r.key[KEY_W-1 -: YEAR_W];
  assign out_month        = out_rec_r.key[DAY_W +: MONTH_W];
  assign out_day          = out_rec_r.key[DAY_W-1:0];
  assign out_price_bits   = out_rec_r.price;
  assign out_final_result = out_final_r;
  assign out_overflowed   = out_ovf_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_COUNT)
    else $error("held count exceeds capacity");

  a_emit_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) |-> (count_r != '0))
    else $error("emission with no held records");

  a_last_starts_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && in_last_item) |=> (state_r == ST_EMIT))
    else $error("last item did not start emission");

  a_set_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && (count_r == CW'(1))) |=> (count_r == '0 && !ovf_r))
    else $error("set not cleared after final result");

endmodule
